/* rtl/dhot_pkg.sv */
// Shared types, codes and constants of the double-hashing key/value table.
package dhot_pkg;

	localparam int MAX_POSITIONS_DEF = 1024;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int HASH_W = 32;
	localparam int ACT_W = 3;
	localparam int RES_W = 3;
	localparam int CNT_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int INIT_POS_RST = 16;
	localparam int MIN_POS_RST = 0;
	localparam int GROW_Q8_RST = 192;
	localparam int SHRINK_Q8_RST = 64;
	localparam int COOLDOWN_RST = 1000;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_UPDATE = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_LOOKUP = 3'd3,
		ACT_CLEAR  = 3'd4,
		ACT_TICK   = 3'd5
	} act_t;

	typedef enum logic [RES_W-1:0] {
		RES_OK        = 3'd0,
		RES_DUP       = 3'd1,
		RES_NOT_FOUND = 3'd2,
		RES_FULL      = 3'd3,
		RES_GROW_FAIL = 3'd4
	} res_t;

	typedef enum logic [1:0] {
		SL_EMPTY = 2'd0,
		SL_LIVE  = 2'd1,
		SL_TOMB  = 2'd2
	} slot_t;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COOL   = 3'd4;

	// slot address sources
	typedef enum logic [2:0] {
		AS_WIPE,
		AS_NEW,
		AS_OLD,
		AS_PROBE,
		AS_FREE,
		AS_HIT
	} asel_t;

	typedef enum logic [4:0] {
		S_WIPE,
		S_IDLE,
		S_DISP,
		S_CLRNEW,
		S_RH_RD,
		S_RH_EV,
		S_RH_NX,
		S_RH_END,
		S_STEP_LD,
		S_STEP_DIV,
		S_GCD_LD,
		S_GCD,
		S_HOME_LD,
		S_HOME_DIV,
		S_PR_RD,
		S_PR_EV,
		S_OP_END,
		S_INS_FIX,
		S_SHR_CHK,
		S_CA_RD,
		S_CA_EV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [HASH_W-1:0] hash_home;
		logic [HASH_W-1:0] hash_stride;
	} in_word_t;

	typedef struct packed {
		logic [RES_W-1:0] status;
		logic [VAL_W-1:0] found_value;
		logic [CNT_W-1:0] entry_count;
		logic [CNT_W-1:0] capacity;
	} out_word_t;

	typedef struct packed {
		logic  cfg_ready;
		logic  item_load;
		logic  swp_clr;
		logic  swp_inc;
		logic  empty_init;
		logic  ri_clr;
		logic  ri_inc;
		logic  ncap_dbl;
		logic  ncap_half;
		logic  commit;
		logic  div_s;
		logic  div_h;
		logic  s_from_rem;
		logic  s_inc;
		logic  gcd_load;
		logic  pos_init;
		logic  pr_eval;
		logic  mv_load;
		logic  rh;
		logic  st_we;
		slot_t st_val;
		logic  pl_we;
		asel_t asel;
		logic  live_inc;
		logic  live_dec;
		logic  live_zero;
		logic  pend_chk;
		logic  shr_chk;
		logic  tick;
		logic  set_res;
		res_t  res;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic init_wr;
		logic swp_last_all;
		logic swp_last_bank;
		logic ri_last;
		logic div_done;
		logic gcd_done;
		logic gcd_one;
		logic rd_empty;
		logic rd_live;
		logic key_eq;
		logic pi_last;
		logic grow_need;
		logic grow_fail;
		logic has_free;
		logic hit;
		logic shrink_go;
	} sts_t;

endpackage

/* rtl/dhot_ctrl.sv */
// Sequencer of the table: probes, rehash, sweeps and result strobe.
module dhot_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dhot_pkg::sts_t sts,
	output dhot_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import dhot_pkg::*;

	state_t state_q, state_d;
	logic   rh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			rh_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				rh_q <= 1'b0;
			else if (cmd.ncap_dbl || cmd.ncap_half)
				rh_q <= 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_WIPE:     if (sts.swp_last_all) state_d = S_IDLE;
			S_IDLE: begin
				if (start)
					state_d = S_DISP;
				else if (sts.init_wr)
					state_d = S_WIPE;
			end
			S_DISP: begin
				if (sts.action inside {ACT_INSERT, ACT_UPDATE}) begin
					if (sts.grow_need)
						state_d = sts.grow_fail ? S_DONE : S_CLRNEW;
					else
						state_d = S_STEP_LD;
				end else if (sts.action inside {ACT_REMOVE, ACT_LOOKUP})
					state_d = S_STEP_LD;
				else if (sts.action == ACT_CLEAR)
					state_d = S_CA_RD;
				else
					state_d = S_DONE;
			end
			S_CLRNEW:   if (sts.swp_last_bank) state_d = S_RH_RD;
			S_RH_RD:    state_d = S_RH_EV;
			S_RH_EV: begin
				if (sts.rd_live)
					state_d = S_STEP_LD;
				else
					state_d = sts.ri_last ? S_RH_END : S_RH_RD;
			end
			S_RH_NX:    state_d = sts.ri_last ? S_RH_END : S_RH_RD;
			S_RH_END:   state_d = (sts.action == ACT_REMOVE) ? S_DONE : S_STEP_LD;
			S_STEP_LD:  state_d = S_STEP_DIV;
			S_STEP_DIV: if (sts.div_done) state_d = S_GCD_LD;
			S_GCD_LD:   state_d = S_GCD;
			S_GCD:      if (sts.gcd_done) state_d = sts.gcd_one ? S_HOME_LD : S_GCD_LD;
			S_HOME_LD:  state_d = S_HOME_DIV;
			S_HOME_DIV: if (sts.div_done) state_d = S_PR_RD;
			S_PR_RD:    state_d = S_PR_EV;
			S_PR_EV: begin
				if (rh_q)
					state_d = (sts.rd_empty || sts.pi_last) ? S_RH_NX : S_PR_RD;
				else if (sts.rd_empty || (sts.rd_live && sts.key_eq) || sts.pi_last)
					state_d = S_OP_END;
				else
					state_d = S_PR_RD;
			end
			S_OP_END: begin
				if (sts.action inside {ACT_INSERT, ACT_UPDATE})
					state_d = (!sts.hit && sts.has_free) ? S_INS_FIX : S_DONE;
				else if (sts.action == ACT_REMOVE)
					state_d = sts.hit ? S_SHR_CHK : S_DONE;
				else
					state_d = S_DONE;
			end
			S_INS_FIX:  state_d = S_DONE;
			S_SHR_CHK:  state_d = sts.shrink_go ? S_CLRNEW : S_DONE;
			S_CA_RD:    state_d = S_CA_EV;
			S_CA_EV:    state_d = sts.ri_last ? S_DONE : S_CA_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.st_val = SL_EMPTY;
		cmd.asel   = AS_PROBE;
		cmd.res    = RES_OK;
		cmd.rh     = rh_q;
		case (state_q)
			S_WIPE: begin
				cmd.st_we   = 1'b1;
				cmd.asel    = AS_WIPE;
				cmd.swp_inc = 1'b1;
				cmd.empty_init = sts.swp_last_all;
			end
			S_IDLE: begin
				cmd.cfg_ready = !start;
				cmd.swp_clr   = 1'b1;
				cmd.ri_clr    = 1'b1;
				cmd.item_load = start;
			end
			S_DISP: begin
				if (sts.action inside {ACT_INSERT, ACT_UPDATE}) begin
					if (sts.grow_need && sts.grow_fail) begin
						cmd.set_res = 1'b1;
						cmd.res     = RES_GROW_FAIL;
					end else if (sts.grow_need)
						cmd.ncap_dbl = 1'b1;
				end else if (sts.action == ACT_TICK)
					cmd.tick = 1'b1;
			end
			S_CLRNEW: begin
				cmd.st_we   = 1'b1;
				cmd.asel    = AS_NEW;
				cmd.swp_inc = 1'b1;
			end
			S_RH_RD: cmd.asel = AS_OLD;
			S_RH_EV: begin
				cmd.asel    = AS_OLD;
				cmd.mv_load = sts.rd_live;
				cmd.ri_inc  = !sts.rd_live && !sts.ri_last;
			end
			S_RH_NX:    cmd.ri_inc = !sts.ri_last;
			S_RH_END:   cmd.commit = 1'b1;
			S_STEP_LD:  cmd.div_s = 1'b1;
			S_STEP_DIV: cmd.s_from_rem = sts.div_done;
			S_GCD_LD:   cmd.gcd_load = 1'b1;
			S_GCD:      cmd.s_inc = sts.gcd_done && !sts.gcd_one;
			S_HOME_LD:  cmd.div_h = 1'b1;
			S_HOME_DIV: cmd.pos_init = sts.div_done;
			S_PR_RD:    cmd.asel = AS_PROBE;
			S_PR_EV: begin
				cmd.asel = AS_PROBE;
				if (rh_q && sts.rd_empty) begin
					cmd.st_we  = 1'b1;
					cmd.st_val = SL_LIVE;
					cmd.pl_we  = 1'b1;
				end else
					cmd.pr_eval = 1'b1;
			end
			S_OP_END: begin
				if (sts.action inside {ACT_INSERT, ACT_UPDATE}) begin
					if (sts.hit) begin
						if (sts.action == ACT_INSERT) begin
							cmd.set_res = 1'b1;
							cmd.res     = RES_DUP;
						end else begin
							cmd.pl_we = 1'b1;
							cmd.asel  = AS_HIT;
						end
					end else if (!sts.has_free) begin
						cmd.set_res = 1'b1;
						cmd.res     = RES_FULL;
					end else begin
						cmd.st_we    = 1'b1;
						cmd.st_val   = SL_LIVE;
						cmd.pl_we    = 1'b1;
						cmd.asel     = AS_FREE;
						cmd.live_inc = 1'b1;
					end
				end else if (sts.action inside {ACT_REMOVE, ACT_LOOKUP}) begin
					if (!sts.hit) begin
						cmd.set_res = 1'b1;
						cmd.res     = RES_NOT_FOUND;
					end else if (sts.action == ACT_REMOVE) begin
						cmd.st_we    = 1'b1;
						cmd.st_val   = SL_TOMB;
						cmd.asel     = AS_HIT;
						cmd.live_dec = 1'b1;
					end
				end
			end
			S_INS_FIX: cmd.pend_chk = 1'b1;
			S_SHR_CHK: begin
				cmd.shr_chk   = 1'b1;
				cmd.ncap_half = sts.shrink_go;
			end
			S_CA_RD: cmd.asel = AS_OLD;
			S_CA_EV: begin
				cmd.asel      = AS_OLD;
				cmd.st_we     = sts.rd_live;
				cmd.st_val    = SL_TOMB;
				cmd.live_zero = sts.ri_last;
				cmd.ri_inc    = !sts.ri_last;
			end
			S_DONE: ;
			default: ;
		endcase
	end

endmodule

/* rtl/dhot_dp.sv */
// Datapath of the table: slot memories, modulo and gcd units, probe and size state.
module dhot_dp #(
	parameter int MAX_POSITIONS = dhot_pkg::MAX_POSITIONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dhot_pkg::cmd_t                        cmd,
	output dhot_pkg::sts_t                        sts,
	input  dhot_pkg::in_word_t                    item,
	input  logic                                 cfg_valid,
	input  logic [dhot_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dhot_pkg::CFG_DATA_W-1:0]       cfg_data,
	output dhot_pkg::out_word_t                   result
);
	import dhot_pkg::*;

	localparam int PW    = $clog2(MAX_POSITIONS);
	localparam int AW    = PW + 1;
	localparam int CW    = $clog2(MAX_POSITIONS + 1);
	localparam int DEPTH = 2 ** AW;
	localparam int PL_W  = KEY_W + VAL_W + 2 * HASH_W;
	localparam int DCW   = $clog2(HASH_W + 1);
	localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_POSITIONS);

	// configuration
	logic [10:0] init_q, min_q;
	logic [8:0]  grow_q;
	logic [7:0]  shr_q;
	logic [15:0] cool_q;
	logic        cfg_we;

	// table state
	logic          bank_q, pend_q;
	logic [CW-1:0] cap_q, ncap_q, live_q;
	logic [15:0]   age_q;

	// item and moved entry
	in_word_t          item_q;
	logic [PL_W-1:0]   mv_q;
	logic [RES_W-1:0]  res_q;
	logic [VAL_W-1:0]  found_q;

	// units and probe
	logic [HASH_W-1:0] dvd_q;
	logic [CW-1:0]     rem_q, s_q, ga_q, gb_q, pi_q;
	logic [DCW-1:0]    dcnt_q;
	logic              bev_q;
	logic [PW-1:0]     pos_q, free_q, hpos_q, ri_q;
	logic              has_free_q, hit_q;
	logic [AW-1:0]     swp_q;

	// memories
	logic [1:0]      st_mem [DEPTH];
	logic [PL_W-1:0] pl_mem [DEPTH];
	logic [1:0]      rd_st;
	logic [PL_W-1:0] rd_pl;

	logic [31:0]     init_w, min_w;
	logic [CW-1:0]   eff_init, eff_min, wcap, half;
	logic [CW+8:0]   gprod;
	logic [CW+7:0]   sprod;
	logic [CW:0]     thr_g;
	logic [CW-1:0]   thr_s;
	logic            live_lt;
	logic [CW:0]     r2, rnext, psum, pnext;
	logic            pbank;
	logic [AW-1:0]   addr;
	logic [PL_W-1:0] wr_pl;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic [HASH_W-1:0] mv_hh, mv_hs;

	assign cfg_we = cfg_valid && cmd.cfg_ready;

	// clamp the configured capacities
	always_comb begin
		init_w = 32'(init_q);
		min_w  = 32'(min_q);
		if (init_w < 32'd2)
			eff_init = CW'(2);
		else if (init_w > 32'(MAX_POSITIONS))
			eff_init = CW'(MAX_POSITIONS);
		else
			eff_init = CW'(init_w);
		if (min_w == 32'd0 || min_w > 32'(eff_init))
			eff_min = eff_init;
		else
			eff_min = CW'(min_w);
	end

	assign gprod   = (CW + 9)'(cap_q) * (CW + 9)'(grow_q);
	assign sprod   = (CW + 8)'(cap_q) * (CW + 8)'(shr_q);
	assign thr_g   = gprod[CW+8:8];
	assign thr_s   = sprod[CW+7:8];
	assign live_lt = live_q < thr_s;
	assign half    = cap_q >> 1;

	assign wcap  = cmd.rh ? ncap_q : cap_q;
	assign pbank = cmd.rh ? ~bank_q : bank_q;

	assign mv_hh = mv_q[2*HASH_W-1:HASH_W];
	assign mv_hs = mv_q[HASH_W-1:0];
	assign rd_key = rd_pl[PL_W-1 -: KEY_W];
	assign rd_val = rd_pl[2*HASH_W +: VAL_W];

	// one quotient bit per cycle
	assign r2    = {rem_q, dvd_q[HASH_W-1]};
	assign rnext = (r2 >= {1'b0, wcap}) ? r2 - {1'b0, wcap} : r2;

	assign psum  = (CW + 1)'(pos_q) + (CW + 1)'(s_q);
	assign pnext = (psum >= {1'b0, wcap}) ? psum - {1'b0, wcap} : psum;

	always_comb begin
		case (cmd.asel)
			AS_WIPE:  addr = swp_q;
			AS_NEW:   addr = {~bank_q, swp_q[PW-1:0]};
			AS_OLD:   addr = {bank_q, ri_q};
			AS_PROBE: addr = {pbank, pos_q};
			AS_FREE:  addr = {bank_q, free_q};
			AS_HIT:   addr = {bank_q, hpos_q};
			default:  addr = {bank_q, pos_q};
		endcase
	end

	assign wr_pl = cmd.rh ? mv_q
		: {item_q.key, item_q.value, item_q.hash_home, item_q.hash_stride};

	always_ff @(posedge clk) begin
		if (cmd.st_we)
			st_mem[addr] <= cmd.st_val;
		rd_st <= st_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.pl_we)
			pl_mem[addr] <= wr_pl;
		rd_pl <= pl_mem[addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.item_load)
			item_q <= item;
		if (cmd.mv_load)
			mv_q <= rd_pl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 11'(INIT_POS_RST);
			min_q      <= 11'(MIN_POS_RST);
			grow_q     <= 9'(GROW_Q8_RST);
			shr_q      <= 8'(SHRINK_Q8_RST);
			cool_q     <= 16'(COOLDOWN_RST);
			bank_q     <= 1'b0;
			pend_q     <= 1'b0;
			cap_q      <= CW'(2);
			ncap_q     <= CW'(2);
			live_q     <= '0;
			age_q      <= '0;
			res_q      <= RES_OK;
			found_q    <= '0;
			dvd_q      <= '0;
			rem_q      <= '0;
			dcnt_q     <= '0;
			s_q        <= CW'(1);
			ga_q       <= CW'(1);
			gb_q       <= '0;
			bev_q      <= 1'b0;
			pi_q       <= '0;
			pos_q      <= '0;
			free_q     <= '0;
			hpos_q     <= '0;
			ri_q       <= '0;
			has_free_q <= 1'b0;
			hit_q      <= 1'b0;
			swp_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INIT:   init_q <= cfg_data[10:0];
					CFG_MIN:    min_q  <= cfg_data[10:0];
					CFG_GROW:   grow_q <= cfg_data[8:0];
					CFG_SHRINK: shr_q  <= cfg_data[7:0];
					CFG_COOL:   cool_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.swp_clr)
				swp_q <= '0;
			else if (cmd.swp_inc)
				swp_q <= swp_q + AW'(1);

			if (cmd.ri_clr)
				ri_q <= '0;
			else if (cmd.ri_inc)
				ri_q <= ri_q + PW'(1);

			if (cmd.empty_init) begin
				bank_q <= 1'b0;
				cap_q  <= eff_init;
				live_q <= '0;
				pend_q <= 1'b0;
				age_q  <= '0;
			end

			if (cmd.item_load) begin
				res_q   <= RES_OK;
				found_q <= '0;
			end else if (cmd.set_res)
				res_q <= cmd.res;

			if (cmd.ncap_dbl)
				ncap_q <= cap_q << 1;
			else if (cmd.ncap_half)
				ncap_q <= half;

			if (cmd.commit) begin
				cap_q  <= ncap_q;
				bank_q <= ~bank_q;
				pend_q <= 1'b0;
			end

			if (cmd.live_inc)
				live_q <= live_q + CW'(1);
			else if (cmd.live_dec)
				live_q <= live_q - CW'(1);
			else if (cmd.live_zero)
				live_q <= '0;

			// cancel a pending shrink once the load has recovered
			if (cmd.pend_chk && pend_q && !live_lt)
				pend_q <= 1'b0;

			if (cmd.shr_chk && live_lt) begin
				if (!pend_q) begin
					pend_q <= 1'b1;
					age_q  <= '0;
				end else if (age_q >= cool_q)
					pend_q <= 1'b0;
			end

			if (cmd.tick && pend_q && age_q != 16'hFFFF)
				age_q <= age_q + 16'd1;

			// modulo unit
			if (cmd.div_s || cmd.div_h) begin
				if (cmd.div_s)
					dvd_q <= cmd.rh ? mv_hs : item_q.hash_stride;
				else
					dvd_q <= cmd.rh ? mv_hh : item_q.hash_home;
				rem_q  <= '0;
				dcnt_q <= DCW'(HASH_W);
			end else if (dcnt_q != '0) begin
				rem_q  <= rnext[CW-1:0];
				dvd_q  <= dvd_q << 1;
				dcnt_q <= dcnt_q - DCW'(1);
			end

			// probe step search
			if (cmd.s_from_rem)
				s_q <= (rem_q == '0) ? CW'(1) : rem_q;
			else if (cmd.s_inc)
				s_q <= (s_q >= wcap - CW'(1)) ? CW'(1) : s_q + CW'(1);

			// binary gcd, one step per cycle
			if (cmd.gcd_load) begin
				ga_q  <= s_q;
				gb_q  <= wcap;
				bev_q <= !s_q[0] && !wcap[0];
			end else if (!bev_q && gb_q != '0) begin
				if (!gb_q[0])
					gb_q <= gb_q >> 1;
				else if (!ga_q[0])
					ga_q <= ga_q >> 1;
				else if (ga_q > gb_q) begin
					ga_q <= gb_q;
					gb_q <= ga_q - gb_q;
				end else
					gb_q <= gb_q - ga_q;
			end

			if (cmd.pos_init) begin
				pos_q      <= rem_q[PW-1:0];
				pi_q       <= '0;
				has_free_q <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.pr_eval) begin
				if (!has_free_q && (rd_st == SL_EMPTY || rd_st == SL_TOMB)) begin
					free_q     <= pos_q;
					has_free_q <= 1'b1;
				end
				if (rd_st == SL_LIVE && rd_key == item_q.key) begin
					hit_q  <= 1'b1;
					hpos_q <= pos_q;
					// hold the value found by the item's own probe during a rehash
					if (!cmd.rh
						&& (item_q.action == ACT_REMOVE || item_q.action == ACT_LOOKUP))
						found_q <= rd_val;
				end
				pos_q <= pnext[PW-1:0];
				pi_q  <= pi_q + CW'(1);
			end
		end
	end

	always_comb begin
		sts               = '0;
		sts.action        = item_q.action;
		sts.init_wr       = cfg_we && cfg_index == CFG_INIT;
		sts.swp_last_all  = &swp_q;
		sts.swp_last_bank = &swp_q[PW-1:0];
		sts.ri_last       = CW'(ri_q) == cap_q - CW'(1);
		sts.div_done      = dcnt_q == '0;
		sts.gcd_done      = bev_q || gb_q == '0;
		sts.gcd_one       = !bev_q && ga_q == CW'(1);
		sts.rd_empty      = rd_st == SL_EMPTY;
		sts.rd_live       = rd_st == SL_LIVE;
		sts.key_eq        = rd_key == item_q.key;
		sts.pi_last       = pi_q == wcap - CW'(1);
		sts.grow_need     = {1'b0, live_q} >= thr_g;
		sts.grow_fail     = {cap_q, 1'b0} > MAX_C;
		sts.has_free      = has_free_q;
		sts.hit           = hit_q;
		sts.shrink_go     = live_lt && pend_q && age_q >= cool_q && half >= eff_min
			&& half >= CW'(2) && half >= live_q;
	end

	assign result.status      = res_q;
	assign result.found_value = found_q;
	assign result.entry_count = CNT_W'(live_q);
	assign result.capacity    = CNT_W'(cap_q);

endmodule

/* rtl/double_hash_open_table.sv */
// Top level of the double-hashing key/value table.
//
// Usage: drive an item word and raise start while busy is low; the item is
// taken at that edge and busy rises on the next cycle. Exactly one result
// word follows, on the result port for one cycle with done high; the
// receiver must take it then, since it cannot hold results off. Busy falls
// the cycle after done, and the next item may be started then.
// Sequence: every probed item runs two modulo passes (step and home
// position), a binary gcd search for a step coprime with the capacity,
// and a read and an evaluation of each probed slot. Clear-all reads and
// evaluates every slot of the capacity. A resize clears the other bank,
// then reads every old slot and reinserts each live entry with the same
// modulo/gcd/probe sequence.
// Reset and any write to the initial_positions register wipe both banks, one
// slot per cycle, busy high throughout. Configuration words are taken on the
// cfg channel only while the block is idle (cfg_ready high).
module double_hash_open_table #(
	parameter int MAX_POSITIONS = dhot_pkg::MAX_POSITIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  dhot_pkg::in_word_t                item,
	output logic                              done,
	output dhot_pkg::out_word_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dhot_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dhot_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dhot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// hold cfg off while busy or while an item is being started
	assign cfg_ready = cmd.cfg_ready;

	dhot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dhot_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

/* bench/tb_double_hash_open_table.sv */
// Testbench for the double-hashing key/value table: directed and random items, checked against a predictor.
`timescale 1ns / 100ps
module tb_double_hash_open_table;
	import dhot_pkg::*;

	// spare action codes: the table must answer them with ok and no change
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
	localparam int BANK = MAX_POSITIONS_DEF;

	// kinds of pending driver work
	localparam int K_ITEM = 0;
	localparam int K_CFG = 1;
	localparam int K_PACE = 2;

	typedef struct {
		int kind;
		in_word_t w;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		int pct;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t item = '0;
	logic done;
	out_word_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	double_hash_open_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	job_t pending[$];
	out_word_t expected_words[$];
	int mismatches = 0;
	int idle_pct = 0;

	// ---------------------------------------------------------------
	// Table shadow: registers, both banks and the bookkeeping state
	// ---------------------------------------------------------------
	int unsigned reg_init, reg_min, reg_grow, reg_shrink, reg_cool;
	slot_t sh_st[0:2*BANK-1];
	logic [KEY_W-1:0] sh_key[0:2*BANK-1];
	logic [VAL_W-1:0] sh_val[0:2*BANK-1];
	logic [HASH_W-1:0] sh_hh[0:2*BANK-1];
	logic [HASH_W-1:0] sh_hs[0:2*BANK-1];
	int unsigned sh_bank, sh_cap, sh_live, sh_age;
	bit sh_pend;

	function automatic int unsigned clamp_init();
		int unsigned v;
		v = reg_init;
		if (v < 2) v = 2;
		if (v > BANK) v = BANK;
		return v;
	endfunction

	function automatic int unsigned floor_cap();
		int unsigned m;
		m = reg_min;
		if (m == 0 || m > clamp_init()) m = clamp_init();
		return m;
	endfunction

	function automatic int unsigned load_limit(int unsigned q8);
		return (sh_cap * q8) >> 8;
	endfunction

	function automatic int unsigned gcd(int unsigned a, int unsigned b);
		int unsigned r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic int unsigned stride_for(logic [HASH_W-1:0] hs, int unsigned cap);
		int unsigned s;
		s = hs % cap;
		if (s == 0) s = 1;
		while (gcd(s, cap) != 1) s = (s >= cap - 1) ? 1 : s + 1;
		return s;
	endfunction

	// walk the chain; report a key hit or the first reusable slot
	function automatic bit find_key(logic [KEY_W-1:0] k, logic [HASH_W-1:0] hh,
			logic [HASH_W-1:0] hs, output int unsigned hit, output int unsigned fr,
			output bit has_free);
		int unsigned base, step, pos;
		base = sh_bank * BANK;
		step = stride_for(hs, sh_cap);
		pos = hh % sh_cap;
		has_free = 0;
		fr = 0;
		hit = 0;
		for (int unsigned i = 0; i < sh_cap; i++) begin
			if (sh_st[base+pos] == SL_EMPTY) begin
				if (!has_free) begin
					fr = pos;
					has_free = 1;
				end
				return 0;
			end
			if (sh_st[base+pos] == SL_TOMB) begin
				if (!has_free) begin
					fr = pos;
					has_free = 1;
				end
			end else if (sh_key[base+pos] == k) begin
				hit = pos;
				return 1;
			end
			pos += step;
			if (pos >= sh_cap) pos -= sh_cap;
		end
		return 0;
	endfunction

	// move live entries into the other bank at a new capacity
	function automatic void rehash_into(int unsigned ncap);
		int unsigned ob, nb, s, d, step, pos;
		ob = sh_bank * BANK;
		nb = (sh_bank ^ 1) * BANK;
		for (int unsigned i = 0; i < BANK; i++) sh_st[nb+i] = SL_EMPTY;
		for (int unsigned i = 0; i < sh_cap; i++) begin
			s = ob + i;
			if (sh_st[s] != SL_LIVE) continue;
			step = stride_for(sh_hs[s], ncap);
			pos = sh_hh[s] % ncap;
			for (int unsigned j = 0; j < ncap; j++) begin
				d = nb + pos;
				if (sh_st[d] == SL_EMPTY) begin
					sh_st[d] = SL_LIVE;
					sh_key[d] = sh_key[s];
					sh_val[d] = sh_val[s];
					sh_hh[d] = sh_hh[s];
					sh_hs[d] = sh_hs[s];
					break;
				end
				pos += step;
				if (pos >= ncap) pos -= ncap;
			end
		end
		sh_bank ^= 1;
		sh_cap = ncap;
		sh_pend = 0;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < 2 * BANK; i++) sh_st[i] = SL_EMPTY;
		sh_bank = 0;
		sh_cap = clamp_init();
		sh_live = 0;
		sh_pend = 0;
		sh_age = 0;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_INIT: begin
				reg_init = v & 16'h7FF;
				wipe_table();
			end
			CFG_MIN: reg_min = v & 16'h7FF;
			CFG_GROW: reg_grow = v & 16'h1FF;
			CFG_SHRINK: reg_shrink = v & 16'hFF;
			CFG_COOL: reg_cool = v;
			default: ;
		endcase
	endfunction

	// apply one item to the shadow and return the result word it must produce
	function automatic out_word_t table_outcome(in_word_t w);
		out_word_t r;
		int unsigned hit, fr, base, d, half;
		bit has_free, ok;
		r = '0;
		r.status = RES_OK;
		if (w.action == ACT_INSERT || w.action == ACT_UPDATE) begin
			ok = 1;
			if (sh_live >= load_limit(reg_grow)) begin
				if (sh_cap * 2 > BANK) begin
					r.status = RES_GROW_FAIL;
					ok = 0;
				end else rehash_into(sh_cap * 2);
			end
			if (ok) begin
				base = sh_bank * BANK;
				if (find_key(w.key, w.hash_home, w.hash_stride, hit, fr, has_free)) begin
					if (w.action == ACT_INSERT) r.status = RES_DUP;
					else begin
						sh_key[base+hit] = w.key;
						sh_val[base+hit] = w.value;
						sh_hh[base+hit] = w.hash_home;
						sh_hs[base+hit] = w.hash_stride;
					end
				end else if (!has_free) r.status = RES_FULL;
				else begin
					d = base + fr;
					sh_st[d] = SL_LIVE;
					sh_key[d] = w.key;
					sh_val[d] = w.value;
					sh_hh[d] = w.hash_home;
					sh_hs[d] = w.hash_stride;
					sh_live++;
					if (sh_pend && sh_live >= load_limit(reg_shrink)) sh_pend = 0;
				end
			end
		end else if (w.action == ACT_REMOVE || w.action == ACT_LOOKUP) begin
			base = sh_bank * BANK;
			if (!find_key(w.key, w.hash_home, w.hash_stride, hit, fr, has_free))
				r.status = RES_NOT_FOUND;
			else begin
				r.found_value = sh_val[base+hit];
				if (w.action == ACT_REMOVE) begin
					sh_st[base+hit] = SL_TOMB;
					sh_live--;
					if (sh_live < load_limit(reg_shrink)) begin
						if (!sh_pend) begin
							sh_pend = 1;
							sh_age = 0;
						end else if (sh_age >= reg_cool) begin
							half = sh_cap / 2;
							sh_pend = 0;
							if (half >= floor_cap() && half >= 2 && half >= sh_live)
								rehash_into(half);
						end
					end
				end
			end
		end else if (w.action == ACT_CLEAR) begin
			base = sh_bank * BANK;
			for (int unsigned i = 0; i < sh_cap; i++)
				if (sh_st[base+i] == SL_LIVE) sh_st[base+i] = SL_TOMB;
			sh_live = 0;
		end else if (w.action == ACT_TICK) begin
			if (sh_pend && sh_age < 16'hFFFF) sh_age++;
		end
		r.entry_count = CNT_W'(sh_live);
		r.capacity = CNT_W'(sh_cap);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: one word or register write at a time from the pending queue
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive
		logic nxt_start, nxt_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			// the word on the bus was taken at this edge: predict, then drop it
			if (start && !busy) begin
				expected_words.push_back(table_outcome(item));
				void'(pending.pop_front());
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				void'(pending.pop_front());
				nxt_cfg = 1'b0;
			end
			// nothing in flight on the bus: pick the next job
			if (!nxt_start && !nxt_cfg) begin
				while (pending.size() > 0 && pending[0].kind == K_PACE) begin
					idle_pct = pending[0].pct;
					void'(pending.pop_front());
				end
				if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					if (pending[0].kind == K_CFG) begin
						// write registers only once every result is back
						if (expected_words.size() == 0) begin
							nxt_cfg = 1'b1;
							cfg_index <= pending[0].idx;
							cfg_data <= pending[0].data;
						end
					end else begin
						nxt_start = 1'b1;
						item <= pending[0].w;
					end
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: every done cycle must match the oldest expected word
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		out_word_t e;
		if (arst_n && done) begin
			if (expected_words.size() == 0)
				report_mismatch("unexpected result word, status", result.status, 0);
			else begin
				e = expected_words.pop_front();
				if (result.status !== e.status)
					report_mismatch("status", result.status, e.status);
				if (result.found_value !== e.found_value)
					report_mismatch("found_value", result.found_value, e.found_value);
				if (result.entry_count !== e.entry_count)
					report_mismatch("entry_count", result.entry_count, e.entry_count);
				if (result.capacity !== e.capacity)
					report_mismatch("capacity", result.capacity, e.capacity);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic [KEY_W-1:0] key_pool[0:63];
	logic [HASH_W-1:0] home_pool[0:63];
	logic [HASH_W-1:0] stride_pool[0:63];

	task automatic push_item(logic [ACT_W-1:0] a, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic [HASH_W-1:0] hh, logic [HASH_W-1:0] hs);
		job_t j;
		j = '{kind: K_ITEM, w: '0, idx: '0, data: '0, pct: 0};
		j.w.action = a;
		j.w.key = k;
		j.w.value = v;
		j.w.hash_home = hh;
		j.w.hash_stride = hs;
		pending.push_back(j);
	endtask

	task automatic push_regs(int unsigned init, int unsigned mn, int unsigned gr,
			int unsigned sr, int unsigned cl);
		logic [CFG_DATA_W-1:0] vals[5];
		logic [CFG_IDX_W-1:0] idxs[5];
		vals = '{CFG_DATA_W'(cl), CFG_DATA_W'(gr), CFG_DATA_W'(sr), CFG_DATA_W'(mn),
			CFG_DATA_W'(init)};
		idxs = '{CFG_COOL, CFG_GROW, CFG_SHRINK, CFG_MIN, CFG_INIT};
		for (int i = 0; i < 5; i++)
			pending.push_back('{kind: K_CFG, w: '0, idx: idxs[i], data: vals[i], pct: 0});
	endtask

	task automatic set_pace(int pct);
		pending.push_back('{kind: K_PACE, w: '0, idx: '0, data: '0, pct: pct});
	endtask

	// well-formed traffic: keys from a pool with their own hashes; some noise
	task automatic random_items(int n, int pool);
		int a, p;
		logic [ACT_W-1:0] act;
		logic [KEY_W-1:0] k;
		logic [HASH_W-1:0] hh, hs;
		for (int i = 0; i < 64; i++) begin
			key_pool[i] = $urandom;
			home_pool[i] = $urandom;
			stride_pool[i] = $urandom;
		end
		for (int i = 0; i < n; i++) begin
			a = $urandom_range(99);
			if (a < 30) act = ACT_INSERT;
			else if (a < 45) act = ACT_UPDATE;
			else if (a < 65) act = ACT_REMOVE;
			else if (a < 85) act = ACT_LOOKUP;
			else if (a < 97) act = ACT_TICK;
			else if (a < 98) act = ACT_CLEAR;
			else act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
			p = $urandom_range(pool - 1);
			k = ($urandom_range(9) == 0) ? $urandom : key_pool[p];
			hh = home_pool[p];
			hs = stride_pool[p];
			if ($urandom_range(9) == 0) hh = $urandom;
			if ($urandom_range(9) == 0) hs = $urandom;
			push_item(act, k, $urandom, hh, hs);
		end
	endtask

	initial begin
		reg_init = INIT_POS_RST;
		reg_min = MIN_POS_RST;
		reg_grow = GROW_Q8_RST;
		reg_shrink = SHRINK_Q8_RST;
		reg_cool = COOLDOWN_RST;
		for (int i = 0; i < 2 * BANK; i++) begin
			sh_key[i] = '0;
			sh_val[i] = '0;
			sh_hh[i] = '0;
			sh_hs[i] = '0;
		end
		wipe_table();

		// directed: field extremes, every action, hits and misses, spare codes
		set_pace(0);
		push_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		push_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(ACT_INSERT, 32'h0, 32'h1234_5678, 32'h0, 32'h0);
		push_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(ACT_UPDATE, 32'h0, 32'hA5A5_5A5A, 32'h0, 32'h0);
		push_item(ACT_UPDATE, 32'h5555_AAAA, 32'h0F0F_F0F0, 32'hAAAA_5555, 32'h8000_0000);
		push_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_TICK, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(ACT_SPARE_7, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
		push_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(ACT_INSERT, 32'h5555_AAAA, 32'h1, 32'hAAAA_5555, 32'h8000_0000);
		random_items(400, 48);

		// smallest table, growth at full load, shrink at once, half the time idle
		push_regs(2, 0, 256, 255, 0);
		set_pace(50);
		random_items(450, 8);

		// out-of-range initial sizes clamp; largest table fails to grow early
		push_regs(1, 2047, 1, 0, 65535);
		set_pace(17);
		random_items(30, 8);
		push_regs(2047, 1024, 1, 0, 65535);
		for (int i = 0; i < 6; i++) push_item(ACT_INSERT, $urandom, $urandom, $urandom, $urandom);
		random_items(250, 16);

		// mid-size table with a floor and a short cooldown
		push_regs(8, 4, 192, 128, 3);
		set_pace(50);
		random_items(450, 40);
		push_regs(16, 0, 128, 100, 1);
		set_pace(0);
		random_items(400, 24);

		while (pending.size() > 0 || expected_words.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hold reset at the start, then release it for good
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#80_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
